>>> hw/rtl/mtb_pkg.sv
package mtb_pkg;

  // Default number of fraction bits of the trail fraction.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int IDX_W  = 8;
  localparam int STEP_W = 16;
  localparam int RED_W  = 8;
  localparam int PER_W  = 16;
  localparam int LEN_W  = 8;
  localparam int CNT_W  = 8;

  // Products of an 8 bit count and a 16 bit period or step.
  localparam int DW = CNT_W + PER_W;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_TRAIL  = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(200);
  localparam logic [LEN_W-1:0] TRAIL_RST  = LEN_W'(30);
  localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(255);

endpackage

>>> hw/rtl/mtb_in_if.sv
interface mtb_in_if
  import mtb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  led_index;
  logic [STEP_W-1:0] anim_step;

  modport source(output valid, led_index, anim_step, input ready);
  modport sink(input valid, led_index, anim_step, output ready);
endinterface

>>> hw/rtl/mtb_out_if.sv
interface mtb_out_if
  import mtb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RED_W-1:0] red_level;

  modport source(output valid, red_level, input ready);
  modport sink(input valid, red_level, output ready);
endinterface

>>> hw/rtl/meteor_trail_brightness_top.sv
// Throughput: one word per cycle while the output skid entry is empty; the trail fraction
// comes from a restoring divider with one pipeline stage per quotient bit (FRAC_BITS + 1 stages).
// Reset (synchronous, active high) empties the pipeline and the output skid buffer and
// loads period 200, trail length 30 and LED count 255.
module meteor_trail_brightness_top
  import mtb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mtb_in_if.sink            led_in,
  mtb_out_if.source         led_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int V_W  = FRAC_BITS + 1;
  localparam int SQ_W = 2 * FRAC_BITS;
  localparam int TW   = SQ_W + 5;
  localparam int BW   = V_W + RED_W;
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam int PEAK_I = (4 * ONE_I + 2) / 5;
  localparam logic [V_W-1:0] ONE  = V_W'(ONE_I);
  localparam logic [V_W-1:0] PEAK = V_W'(PEAK_I);

  // Configuration registers.
  logic [PER_W-1:0] period_steps;
  logic [LEN_W-1:0] trail_length;
  logic [CNT_W-1:0] led_count;
  logic             cfg_write;
  logic [1:0]       cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      period_steps <= PERIOD_RST;
      trail_length <= TRAIL_RST;
      led_count    <= COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PERIOD: period_steps <= pwdata[PER_W-1:0];
        REG_TRAIL:  trail_length <= pwdata[LEN_W-1:0];
        REG_COUNT:  led_count    <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_PERIOD: prdata = DATA_W'(period_steps);
      REG_TRAIL:  prdata = DATA_W'(trail_length);
      REG_COUNT:  prdata = DATA_W'(led_count);
      default:    prdata = '0;
    endcase
  end

  // The whole pipeline moves together; the skid buffer at the end absorbs one word
  // when the output is stalled.
  logic pipe_en;
  logic skid_valid;

  assign pipe_en      = !skid_valid;
  assign led_in.ready = pipe_en;

  // Stage 1: range checks and the four small products.
  logic [PER_W-1:0] per_eff;
  logic [CNT_W-1:0] cnt_m1;
  logic [LEN_W-1:0] len_eff;
  logic             s1_valid, s1_dark;
  logic [DW-1:0]    s1_pos, s1_phase, s1_span, s1_dd;

  assign per_eff = (period_steps == '0) ? PER_W'(1) : period_steps;
  assign cnt_m1  = led_count - CNT_W'(1);
  assign len_eff = (trail_length > cnt_m1) ? cnt_m1 : trail_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= led_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_dark  <= (led_in.led_index >= led_count) || (len_eff == '0);
      s1_pos   <= DW'(led_count - led_in.led_index) * DW'(per_eff);
      s1_phase <= DW'(led_in.anim_step) * DW'(led_count);
      s1_span  <= DW'(led_count) * DW'(per_eff);
      s1_dd    <= DW'(len_eff) * DW'(per_eff);
    end
  end

  // Stage 2: wrap the position by one full strip when it lies behind the phase.
  logic            s2_valid, s2_dark;
  logic [DW:0]     s2_pos;
  logic [DW-1:0]   s2_phase, s2_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_dark  <= s1_dark;
      s2_pos   <= (s1_pos < s1_phase) ? ({1'b0, s1_pos} + {1'b0, s1_span}) : {1'b0, s1_pos};
      s2_phase <= s1_phase;
      s2_dd    <= s1_dd;
    end
  end

  // Stage 3: distance past the phase.
  logic          s3_valid, s3_dark;
  logic [DW:0]   s3_dist;
  logic [DW-1:0] s3_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (pipe_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_dark <= s2_dark || (s2_pos < {1'b0, s2_phase});
      s3_dist <= s2_pos - {1'b0, s2_phase};
      s3_dd   <= s2_dd;
    end
  end

  // Divider: stage k settles quotient bit FRAC_BITS - k. The first stage also marks
  // words that lie beyond the end of the trail.
  logic           div_valid [0:FRAC_BITS];
  logic           div_dark  [0:FRAC_BITS];
  logic [DW-1:0]  div_rem   [0:FRAC_BITS];
  logic [DW-1:0]  div_dd    [0:FRAC_BITS];
  logic [V_W-1:0] div_q     [0:FRAC_BITS];
  logic           first_fits;

  assign first_fits = s3_dist >= {1'b0, s3_dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (pipe_en) begin
      div_valid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      div_dark[0] <= s3_dark || (s3_dist > {1'b0, s3_dd});
      div_rem[0]  <= first_fits ? DW'(s3_dist - {1'b0, s3_dd}) : s3_dist[DW-1:0];
      div_dd[0]   <= s3_dd;
      div_q[0]    <= V_W'(first_fits);
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
    logic [DW:0] trial;
    logic        fits;

    assign trial = {div_rem[k-1], 1'b0};
    assign fits  = trial >= {1'b0, div_dd[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[k] <= 1'b0;
      end else if (pipe_en) begin
        div_valid[k] <= div_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        div_dark[k] <= div_dark[k-1];
        div_rem[k]  <= fits ? DW'(trial - {1'b0, div_dd[k-1]}) : trial[DW-1:0];
        div_dd[k]   <= div_dd[k-1];
        div_q[k]    <= {div_q[k-1][V_W-2:0], fits};
      end
    end
  end

  // Stage A: pick the rising or the falling ramp.
  logic                 a_valid, a_dark, a_low;
  logic [FRAC_BITS-1:0] a_mag;
  logic [V_W-1:0]       v_frac;
  logic                 v_low;

  assign v_frac = div_q[FRAC_BITS];
  assign v_low  = v_frac < PEAK;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pipe_en) begin
      a_valid <= div_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_dark <= div_dark[FRAC_BITS];
      a_low  <= v_low;
      a_mag  <= v_low ? v_frac[FRAC_BITS-1:0] : FRAC_BITS'(ONE - v_frac);
    end
  end

  // Stage B: square.
  logic            b_valid, b_dark, b_low;
  logic [SQ_W-1:0] b_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pipe_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_dark <= a_dark;
      b_low  <= a_low;
      b_sq   <= SQ_W'(a_mag) * SQ_W'(a_mag);
    end
  end

  // Stage C: times 25, ramp scaling and saturation at one.
  logic           c_valid, c_dark;
  logic [V_W-1:0] c_bright;
  logic [TW-1:0]  sq25, sq_shift;

  assign sq25     = (TW'(b_sq) << 4) + (TW'(b_sq) << 3) + TW'(b_sq);
  assign sq_shift = b_low ? (sq25 >> (FRAC_BITS + 4)) : (sq25 >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (pipe_en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c_dark   <= b_dark;
      c_bright <= (sq_shift > TW'(ONE)) ? ONE : sq_shift[V_W-1:0];
    end
  end

  // Stage D: scale to 0..255.
  logic             d_valid;
  logic [RED_W-1:0] d_red;
  logic [BW-1:0]    bright255;

  assign bright255 = (BW'(c_bright) << 8) - BW'(c_bright);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (pipe_en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d_red <= c_dark ? '0 : bright255[FRAC_BITS +: RED_W];
    end
  end

  // Output register with one skid entry behind it.
  logic             out_valid;
  logic [RED_W-1:0] out_red;
  logic [RED_W-1:0] skid_red;
  logic             d_take, out_free;

  assign d_take   = d_valid && pipe_en;
  assign out_free = !out_valid || led_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= d_take;
      end
    end else if (d_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_red <= skid_valid ? skid_red : d_red;
    end else if (d_take) begin
      skid_red <= d_red;
    end
  end

  assign led_out.valid     = out_valid;
  assign led_out.red_level = out_red;

`ifndef ASSERT_OFF
  // The skid entry is only ever filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  // A stalled pipeline keeps its last stage unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!pipe_en && d_valid) |=> (d_valid && $stable(d_red)))
    else $error("last pipeline stage changed during a stall");

  // The shaped brightness never exceeds one.
  a_bright_sat: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> (c_bright <= ONE))
    else $error("brightness above full scale");

  // When the output word is taken, a waiting skid word moves on and leaves the skid empty.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && led_out.ready) |=> !skid_valid)
    else $error("skid entry not drained when the output was taken");
`endif

endmodule

>>> dv/meteor_trail_brightness_top_test.sv
`timescale 1ns / 100ps

module meteor_trail_brightness_top_test
  import mtb_pkg::*;
();

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = FRAC + 8;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned PEAK = (4 * ONE + 2) / 5;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [PER_W-1:0]  period;
    logic [LEN_W-1:0]  trail;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  idx;
    logic [STEP_W-1:0] step;
    logic              known;
    logic [RED_W-1:0]  red;
  } row_t;

  // Words with known = 1 carry a level that is plain from the geometry: out of
  // range, the head of the meteor, the far end of the trail, or a dark strip.
  localparam row_t DIRECTED [28] = '{
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd255, 16'd0,     1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd200,   1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd225, 16'd200,   1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd224, 16'd200,   1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd226, 16'd200,   1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd240, 16'd200,   1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd65535, 1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd254, 16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd128, 16'd100,   1'b0, 8'd0},
    '{ROW_CFG,  16'd0,     8'd30,  8'd255, 8'd0,   16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd1,     1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd230, 16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd240, 16'd1,     1'b0, 8'd0},
    '{ROW_CFG,  16'd200,   8'd255, 8'd255, 8'd0,   16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd1,   16'd0,     1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd128, 16'd100,   1'b0, 8'd0},
    '{ROW_CFG,  16'd200,   8'd30,  8'd1,   8'd0,   16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd0,     1'b1, 8'd0},
    '{ROW_CFG,  16'd200,   8'd30,  8'd0,   8'd0,   16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd0,     1'b1, 8'd0},
    '{ROW_CFG,  16'd65535, 8'd1,   8'd2,   8'd0,   16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd1,   16'd0,     1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd65535, 1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd1,   16'd16384, 1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd2,   16'd0,     1'b1, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd255, 16'd65535, 1'b1, 8'd0},
    '{ROW_CFG,  16'd200,   8'd0,   8'd255, 8'd0,   16'd0,     1'b0, 8'd0},
    '{ROW_WORD, 16'd0,     8'd0,   8'd0,   8'd0,   16'd100,   1'b1, 8'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mtb_in_if led_in ();
  mtb_out_if led_out ();

  meteor_trail_brightness_top dut (
    .clk     (clk),
    .rst     (rst),
    .led_in  (led_in),
    .led_out (led_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers as the block should hold them.
  logic [PER_W-1:0] cur_period = PERIOD_RST;
  logic [LEN_W-1:0] cur_trail = TRAIL_RST;
  logic [CNT_W-1:0] cur_count = COUNT_RST;

  logic [RED_W-1:0] pending_red [$];
  int mismatch_count = 0;
  int results_seen = 0;
  bit sender_steady = 1'b0;

  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  int rx_cycles = 0;
  int rx_pick;
  logic [RED_W-1:0] want_red;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [RED_W-1:0] red_for(input logic [IDX_W-1:0] idx,
                                               input logic [STEP_W-1:0] step);
    longint unsigned n, p, len, pos, phase, d, dd, v, w, b;
    n = cur_count;
    p = (cur_period == '0) ? 1 : cur_period;
    if (idx >= n) return '0;
    len = cur_trail;
    if (len > n - 1) len = n - 1;
    if (len == 0) return '0;
    pos = (n - idx) * p;
    phase = step * n;
    // An LED behind the phase belongs to the next lap of the strip.
    if (pos < phase) pos = pos + n * p;
    if (pos < phase) return '0;
    d = pos - phase;
    dd = len * p;
    if (d > dd) return '0;
    v = (d << FRAC) / dd;
    if (v < PEAK) begin
      b = (25 * v * v) >> (FRAC + 4);
    end else begin
      w = ONE - v;
      b = (25 * w * w) >> FRAC;
    end
    if (b > ONE) b = ONE;
    return RED_W'((255 * b) >> FRAC);
  endfunction

  task automatic write_reg(input logic [1:0] sel, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({sel, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [PER_W-1:0] period, input logic [LEN_W-1:0] trail,
                            input logic [CNT_W-1:0] count);
    write_reg(REG_PERIOD, DATA_W'(period));
    write_reg(REG_TRAIL, DATA_W'(trail));
    write_reg(REG_COUNT, DATA_W'(count));
    cur_period = period;
    cur_trail = trail;
    cur_count = count;
  endtask

  // Lowers valid and waits until every word sent so far has come back.
  task automatic drain_words();
    led_in.valid <= 1'b0;
    do @(posedge clk); while (pending_red.size() != 0);
  endtask

  task automatic send_word(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] step,
                           input logic known, input logic [RED_W-1:0] red);
    int r;
    int gap;
    led_in.valid <= 1'b1;
    led_in.led_index <= idx;
    led_in.anim_step <= step;
    do @(posedge clk); while (!led_in.ready);
    pending_red.push_back(known ? red : red_for(idx, step));
    r = $urandom_range(0, 99);
    if (sender_steady || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      led_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      led_out.ready <= 1'b0;
    end else begin
      if (led_out.valid && led_out.ready) begin
        results_seen++;
        if (pending_red.size() == 0) begin
          mismatch_count++;
          $display("%0t: red_level expected none, actual %0d", $time, led_out.red_level);
        end else begin
          want_red = pending_red.pop_front();
          if (led_out.red_level !== want_red) begin
            mismatch_count++;
            $display("%0t: red_level expected %0d, actual %0d", $time, want_red,
                     led_out.red_level);
          end
        end
      end
      rx_cycles++;
      // One long hold-off lets the pipeline fill and push back on the input.
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        led_out.ready <= 1'b0;
      end else if (rx_cycles % 512 < 128) begin
        led_out.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        led_out.ready <= 1'b0;
      end else begin
        led_out.ready <= 1'b1;
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 15) stall_left = $urandom_range(1, 3);
        else if (rx_pick < 17) stall_left = $urandom_range(10, 40);
      end
    end
  end

  initial begin : stimulus
    longint unsigned pe, le, nn, ss, head, off;
    logic [IDX_W-1:0] idx;
    logic [STEP_W-1:0] step;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    led_in.valid = 1'b0;
    led_in.led_index = '0;
    led_in.anim_step = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_words();
        set_config(DIRECTED[i].period, DIRECTED[i].trail, DIRECTED[i].count);
      end else begin
        send_word(DIRECTED[i].idx, DIRECTED[i].step, DIRECTED[i].known, DIRECTED[i].red);
      end
    end
    drain_words();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(PERIOD_RST, TRAIL_RST, COUNT_RST);
        1: set_config(PER_W'(1), LEN_W'(1), CNT_W'(2));
        2: set_config(PER_W'(65535), LEN_W'(254), CNT_W'(255));
        3: set_config(PER_W'(65535), LEN_W'(255), CNT_W'(255));
        default: set_config(PER_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 255)),
                            CNT_W'($urandom_range(2, 255)));
      endcase
      for (int k = 0; k < 100; k++) begin
        sender_steady = (k < 25);
        if (ph == 5 && k == 50) drain_words();
        nn = cur_count;
        if ($urandom_range(0, 99) < 80 && nn != 0) begin
          // Aim at the lit part of the strip: pick a step, then an LED up to
          // one trail length behind the head of the meteor.
          pe = (cur_period == '0) ? 1 : cur_period;
          le = (cur_trail > nn - 1) ? nn - 1 : cur_trail;
          ss = $urandom_range(0, int'(pe));
          head = nn - (ss * nn) / pe;
          off = (le == 0) ? 0 : $urandom_range(0, int'(le));
          idx = IDX_W'((head + nn - off) % nn);
          step = STEP_W'(ss);
        end else begin
          idx = IDX_W'($urandom_range(0, 255));
          step = STEP_W'($urandom_range(0, 65535));
        end
        send_word(idx, step, 1'b0, '0);
      end
      drain_words();
    end

    repeat (4 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
